>>> hw/rtl/rdgs_pkg.sv
// Shared types and constants for the rectangle dimension and row-gap statistics block.
// Used by rdgs_accum, rdgs_div and the top level; depends on nothing else.
`default_nettype none

package rdgs_pkg;

  localparam int COORD_BITS = 12;
  localparam int TOTAL_BITS = 22;
  localparam int STEP_W     = $clog2(TOTAL_BITS);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [TOTAL_BITS-1:0] total_t;

  localparam coord_t COORD_MAX    = {COORD_BITS{1'b1}};
  localparam total_t TOTAL_MAX    = {TOTAL_BITS{1'b1}};
  localparam coord_t DEFAULT_STEP = COORD_BITS'(10);

  // Extremes and overflow flag of one completed set.
  typedef struct packed {
    coord_t len_lo;
    coord_t len_hi;
    coord_t wid_lo;
    coord_t wid_hi;
    logic   overflow;
  } extremes_t;

endpackage

`default_nettype wire

>>> hw/rtl/rdgs_accum.sv
// Running accumulators for extremes, saturating totals and counts of one set.
// On the last transfer the updated figures are frozen into result registers.
// Depends on rdgs_pkg.
`default_nettype none

module rdgs_accum #(
  parameter int MAX_ITEMS = 1024,
  parameter int CNT_W     = 11
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      take,
  input  wire                      last,
  input  wire rdgs_pkg::coord_t    length,
  input  wire rdgs_pkg::coord_t    width,
  input  wire rdgs_pkg::coord_t    row,
  output rdgs_pkg::extremes_t      res_ext,
  output rdgs_pkg::total_t         res_len_total,
  output rdgs_pkg::total_t         res_wid_total,
  output rdgs_pkg::total_t         res_gap_total,
  output logic [CNT_W-1:0]         res_item_count,
  output logic [CNT_W-1:0]         res_gap_count
);

  rdgs_pkg::extremes_t ext_r, ext_nxt;
  rdgs_pkg::total_t    len_total_r, len_total_nxt;
  rdgs_pkg::total_t    wid_total_r, wid_total_nxt;
  rdgs_pkg::total_t    gap_total_r, gap_total_nxt;
  logic [CNT_W-1:0]    item_count_r, item_count_nxt;
  logic [CNT_W-1:0]    gap_count_r, gap_count_nxt;
  rdgs_pkg::coord_t    prev_row_r;
  logic                have_prev_r;
  logic                room;
  logic                new_gap;
  rdgs_pkg::coord_t    row_diff;

  function automatic rdgs_pkg::total_t sat_add(rdgs_pkg::total_t a, rdgs_pkg::total_t b);
    logic [rdgs_pkg::TOTAL_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[rdgs_pkg::TOTAL_BITS] ? rdgs_pkg::TOTAL_MAX : s[rdgs_pkg::TOTAL_BITS-1:0];
  endfunction

  assign room     = (item_count_r < CNT_W'(MAX_ITEMS));
  assign new_gap  = have_prev_r && (row != prev_row_r);
  assign row_diff = (row > prev_row_r) ? (row - prev_row_r) : (prev_row_r - row);

  always_comb begin
    ext_nxt        = ext_r;
    len_total_nxt  = len_total_r;
    wid_total_nxt  = wid_total_r;
    gap_total_nxt  = gap_total_r;
    item_count_nxt = item_count_r;
    gap_count_nxt  = gap_count_r;
    if (length < ext_r.len_lo) ext_nxt.len_lo = length;
    if (length > ext_r.len_hi) ext_nxt.len_hi = length;
    if (width < ext_r.wid_lo) ext_nxt.wid_lo = width;
    if (width > ext_r.wid_hi) ext_nxt.wid_hi = width;
    if (room) begin
      len_total_nxt  = sat_add(len_total_r, rdgs_pkg::TOTAL_BITS'(length));
      wid_total_nxt  = sat_add(wid_total_r, rdgs_pkg::TOTAL_BITS'(width));
      item_count_nxt = item_count_r + CNT_W'(1);
      if (new_gap) begin
        gap_total_nxt = sat_add(gap_total_r, rdgs_pkg::TOTAL_BITS'(row_diff));
        gap_count_nxt = gap_count_r + CNT_W'(1);
      end
    end else begin
      ext_nxt.overflow = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && last)) begin
      ext_r.len_lo <= rdgs_pkg::COORD_MAX;
      ext_r.len_hi <= '0;
      ext_r.wid_lo <= rdgs_pkg::COORD_MAX;
      ext_r.wid_hi <= '0;
      ext_r.overflow   <= 1'b0;
      len_total_r      <= '0;
      wid_total_r      <= '0;
      gap_total_r      <= '0;
      item_count_r     <= '0;
      gap_count_r      <= '0;
      prev_row_r       <= '0;
      have_prev_r      <= 1'b0;
    end else if (take) begin
      ext_r        <= ext_nxt;
      len_total_r  <= len_total_nxt;
      wid_total_r  <= wid_total_nxt;
      gap_total_r  <= gap_total_nxt;
      item_count_r <= item_count_nxt;
      gap_count_r  <= gap_count_nxt;
      prev_row_r   <= row;
      have_prev_r  <= 1'b1;
    end
  end

  // Frozen figures of the set that has just closed.
  always_ff @(posedge clk) begin
    if (take && last) begin
      res_ext        <= ext_nxt;
      res_len_total  <= len_total_nxt;
      res_wid_total  <= wid_total_nxt;
      res_gap_total  <= gap_total_nxt;
      res_item_count <= item_count_nxt;
      res_gap_count  <= gap_count_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/rdgs_div.sv
// Shared restoring divider, one quotient bit per cycle, quotient clamped to coordinate range.
// Depends on rdgs_pkg.
`default_nettype none

module rdgs_div #(
  parameter int DEN_W = 11
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     start,
  input  wire rdgs_pkg::total_t   dividend,
  input  wire [DEN_W-1:0]         divisor,
  output logic                    busy,
  output logic                    done,
  output rdgs_pkg::coord_t        quotient
);

  localparam int MSB = rdgs_pkg::TOTAL_BITS - 1;

  rdgs_pkg::total_t            quo_r;
  logic [DEN_W-1:0]            rem_r;
  logic [DEN_W-1:0]            den_r;
  logic [rdgs_pkg::STEP_W-1:0] step_r;
  logic                        busy_r;
  logic                        done_r;
  logic [DEN_W:0]              trial;
  logic [DEN_W:0]              diff;
  logic                        fits;

  assign trial = {rem_r, quo_r[MSB]};
  assign fits  = (trial >= {1'b0, den_r});
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (step_r == rdgs_pkg::STEP_W'(MSB))) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r  <= dividend;
      rem_r  <= '0;
      den_r  <= divisor;
      step_r <= '0;
    end else if (busy_r) begin
      rem_r  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_r  <= {quo_r[MSB-1:0], fits};
      step_r <= step_r + rdgs_pkg::STEP_W'(1);
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = (|quo_r[MSB:rdgs_pkg::COORD_BITS]) ? rdgs_pkg::COORD_MAX
                                                       : quo_r[rdgs_pkg::COORD_BITS-1:0];

endmodule

`default_nettype wire

>>> hw/rtl/rect_dimension_and_row_gap_stats_core.sv
// Throughput: items that are not last are taken one per cycle, back to back.
// A last item closes the set; three divisions then run in turn on the shared
// one-bit-per-cycle divider, and out_valid rises when the publish state loads the
// result, which waits while the output register still holds an unread result.
// The block takes no item until that result is loaded into the output register.
// Reset: synchronous, active low; clears all running statistics and the output valid.
`default_nettype none

module rect_dimension_and_row_gap_stats_core #(
  parameter int MAX_ITEMS = 1024
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire rdgs_pkg::coord_t  in_rect_length,
  input  wire rdgs_pkg::coord_t  in_rect_width,
  input  wire rdgs_pkg::coord_t  in_scan_row,
  input  wire                    in_last_item,
  output logic                   out_valid,
  input  wire                    out_ready,
  output rdgs_pkg::coord_t       out_avg_length,
  output rdgs_pkg::coord_t       out_avg_width,
  output rdgs_pkg::coord_t       out_min_length,
  output rdgs_pkg::coord_t       out_max_length,
  output rdgs_pkg::coord_t       out_min_width,
  output rdgs_pkg::coord_t       out_max_width,
  output rdgs_pkg::coord_t       out_row_step,
  output logic                   out_overflow
);

  // The item count must be able to hold MAX_ITEMS itself.
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_LEN,
    ST_DIV_WID,
    ST_DIV_GAP,
    ST_PUBLISH
  } state_t;

  state_t              state_r;
  logic                take;
  rdgs_pkg::extremes_t res_ext;
  rdgs_pkg::total_t    res_len_total;
  rdgs_pkg::total_t    res_wid_total;
  rdgs_pkg::total_t    res_gap_total;
  logic [CNT_W-1:0]    res_item_count;
  logic [CNT_W-1:0]    res_gap_count;
  logic                div_start;
  logic                div_busy;
  logic                div_done;
  rdgs_pkg::total_t    div_dividend;
  logic [CNT_W-1:0]    div_divisor;
  rdgs_pkg::coord_t    div_quotient;
  rdgs_pkg::coord_t    len_mean_r;
  rdgs_pkg::coord_t    wid_mean_r;
  rdgs_pkg::coord_t    row_step_r;
  logic                out_valid_r;
  logic                out_free;

  // Input transfers are taken only while no set is being closed off.
  assign in_ready = (state_r == ST_IDLE);
  assign take     = in_valid && in_ready;

  rdgs_accum #(
    .MAX_ITEMS (MAX_ITEMS),
    .CNT_W     (CNT_W)
  ) u_accum (
    .clk            (clk),
    .rst_n          (rst_n),
    .take           (take),
    .last           (in_last_item),
    .length         (in_rect_length),
    .width          (in_rect_width),
    .row            (in_scan_row),
    .res_ext        (res_ext),
    .res_len_total  (res_len_total),
    .res_wid_total  (res_wid_total),
    .res_gap_total  (res_gap_total),
    .res_item_count (res_item_count),
    .res_gap_count  (res_gap_count)
  );

  // The divider is launched once on entry to each division state: it is neither busy
  // nor just finished in that first cycle.
  assign div_start = ((state_r == ST_DIV_LEN) || (state_r == ST_DIV_WID) ||
                      (state_r == ST_DIV_GAP)) && !div_busy && !div_done;

  always_comb begin
    unique case (state_r)
      ST_DIV_WID: begin
        div_dividend = res_wid_total;
        div_divisor  = res_item_count;
      end
      ST_DIV_GAP: begin
        div_dividend = res_gap_total;
        div_divisor  = res_gap_count;
      end
      default: begin
        div_dividend = res_len_total;
        div_divisor  = res_item_count;
      end
    endcase
  end

  rdgs_div #(
    .DEN_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // The output register is free when empty or when its result is transferred now.
  assign out_free = !out_valid_r || out_ready;

  // Sequencer and output register. The item count is never zero once a set closes,
  // because the last item is counted unless the item limit is already reached; the
  // gap count may be zero, and then the default row step replaces the divider's answer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // A new result loaded in the publish state keeps the valid high instead.
      if (out_valid_r && out_ready && (state_r != ST_PUBLISH)) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (take && in_last_item) state_r <= ST_DIV_LEN;
        end
        ST_DIV_LEN: begin
          if (div_done) begin
            len_mean_r <= (res_item_count == '0) ? '0 : div_quotient;
            state_r    <= ST_DIV_WID;
          end
        end
        ST_DIV_WID: begin
          if (div_done) begin
            wid_mean_r <= (res_item_count == '0) ? '0 : div_quotient;
            state_r    <= ST_DIV_GAP;
          end
        end
        ST_DIV_GAP: begin
          if (div_done) begin
            row_step_r <= (res_gap_count == '0) ? rdgs_pkg::DEFAULT_STEP : div_quotient;
            state_r    <= ST_PUBLISH;
          end
        end
        ST_PUBLISH: begin
          if (out_free) begin
            out_valid_r    <= 1'b1;
            out_avg_length <= len_mean_r;
            out_avg_width  <= wid_mean_r;
            out_min_length <= res_ext.len_lo;
            out_max_length <= res_ext.len_hi;
            out_min_width  <= res_ext.wid_lo;
            out_max_width  <= res_ext.wid_hi;
            out_row_step   <= row_step_r;
            out_overflow   <= res_ext.overflow;
            state_r        <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> sim/rect_dimension_and_row_gap_stats_checker.sv
// Scoreboard for the rectangle statistics core: watches both channels, predicts each set summary.
// Depends on rdgs_pkg for the coordinate and total types and the extremes record.
module rect_dimension_and_row_gap_stats_checker #(
  parameter int MAX_ITEMS = 1024
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  input  wire               in_ready,
  input  wire rdgs_pkg::coord_t in_rect_length,
  input  wire rdgs_pkg::coord_t in_rect_width,
  input  wire rdgs_pkg::coord_t in_scan_row,
  input  wire               in_last_item,
  input  wire               out_valid,
  input  wire               out_ready,
  input  wire rdgs_pkg::coord_t out_avg_length,
  input  wire rdgs_pkg::coord_t out_avg_width,
  input  wire rdgs_pkg::coord_t out_min_length,
  input  wire rdgs_pkg::coord_t out_max_length,
  input  wire rdgs_pkg::coord_t out_min_width,
  input  wire rdgs_pkg::coord_t out_max_width,
  input  wire rdgs_pkg::coord_t out_row_step,
  input  wire               out_overflow,
  output int                faults,
  output int                pending,
  output int                results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COUNT_BITS = $clog2(MAX_ITEMS + 1);

  typedef logic [COUNT_BITS-1:0] count_t;

  typedef struct packed {
    rdgs_pkg::coord_t    len_mean;
    rdgs_pkg::coord_t    wid_mean;
    rdgs_pkg::extremes_t bounds;
    rdgs_pkg::coord_t    row_step;
  } rect_summary_t;

  // Running statistics of the set in progress.
  rdgs_pkg::coord_t shortest_len, longest_len, narrowest_wid, widest_wid, last_row;
  rdgs_pkg::total_t len_sum, wid_sum, gap_sum;
  count_t rect_count, gap_count;
  logic   row_seen, too_many;

  rect_summary_t summaries_due[$];
  rect_summary_t due_now;

  task automatic report_fault(input string what);
    $display("[%0t] checker: %s", $time, what);
    faults++;
  endtask

  task automatic check_field(input string field, input rdgs_pkg::coord_t seen,
                             input rdgs_pkg::coord_t due);
    if (seen !== due) begin
      report_fault($sformatf("summary %0d: %s is %0d, expected %0d",
                             results_checked, field, seen, due));
    end
  endtask

  function automatic rdgs_pkg::total_t add_clamped(input rdgs_pkg::total_t a,
                                                   input rdgs_pkg::total_t b);
    logic [rdgs_pkg::TOTAL_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, rdgs_pkg::TOTAL_MAX}) ? rdgs_pkg::TOTAL_MAX
                                             : s[rdgs_pkg::TOTAL_BITS-1:0];
  endfunction

  // Truncated mean, clamped to the coordinate range; an empty divisor gives the fallback.
  function automatic rdgs_pkg::coord_t mean_of(input rdgs_pkg::total_t sum, input count_t n,
                                               input rdgs_pkg::coord_t fallback);
    rdgs_pkg::total_t q;
    if (n == '0) return fallback;
    q = sum / rdgs_pkg::total_t'(n);
    return (q > rdgs_pkg::total_t'(rdgs_pkg::COORD_MAX)) ? rdgs_pkg::COORD_MAX
                                                         : q[rdgs_pkg::COORD_BITS-1:0];
  endfunction

  task automatic clear_stats();
    shortest_len  = rdgs_pkg::COORD_MAX;
    longest_len   = '0;
    narrowest_wid = rdgs_pkg::COORD_MAX;
    widest_wid    = '0;
    len_sum       = '0;
    wid_sum       = '0;
    gap_sum       = '0;
    rect_count    = '0;
    gap_count     = '0;
    last_row      = '0;
    row_seen      = 1'b0;
    too_many      = 1'b0;
  endtask

  task automatic absorb_rect(input rdgs_pkg::coord_t len, input rdgs_pkg::coord_t wid,
                             input rdgs_pkg::coord_t row, input logic last);
    rect_summary_t    due;
    rdgs_pkg::coord_t row_jump;
    if (len < shortest_len)  shortest_len  = len;
    if (len > longest_len)   longest_len   = len;
    if (wid < narrowest_wid) narrowest_wid = wid;
    if (wid > widest_wid)    widest_wid    = wid;
    // Past the item limit only the extremes and the row follow the input.
    if (rect_count < MAX_ITEMS) begin
      len_sum = add_clamped(len_sum, rdgs_pkg::total_t'(len));
      wid_sum = add_clamped(wid_sum, rdgs_pkg::total_t'(wid));
      rect_count++;
      if (row_seen && row != last_row) begin
        row_jump = (row > last_row) ? row - last_row : last_row - row;
        gap_sum = add_clamped(gap_sum, rdgs_pkg::total_t'(row_jump));
        gap_count++;
      end
    end else begin
      too_many = 1'b1;
    end
    last_row = row;
    row_seen = 1'b1;
    if (last) begin
      due.len_mean        = mean_of(len_sum, rect_count, '0);
      due.wid_mean        = mean_of(wid_sum, rect_count, '0);
      due.bounds.len_lo   = shortest_len;
      due.bounds.len_hi   = longest_len;
      due.bounds.wid_lo   = narrowest_wid;
      due.bounds.wid_hi   = widest_wid;
      due.bounds.overflow = too_many;
      due.row_step        = mean_of(gap_sum, gap_count, rdgs_pkg::DEFAULT_STEP);
      summaries_due.push_back(due);
      clear_stats();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_stats();
      summaries_due.delete();
    end else begin
      if (in_valid && in_ready) begin
        absorb_rect(in_rect_length, in_rect_width, in_scan_row, in_last_item);
      end
      if (out_valid && out_ready) begin
        if (summaries_due.size() == 0) begin
          report_fault("summary transfer with no closed set waiting");
        end else begin
          due_now = summaries_due.pop_front();
          check_field("mean length",     out_avg_length, due_now.len_mean);
          check_field("mean width",      out_avg_width,  due_now.wid_mean);
          check_field("shortest length", out_min_length, due_now.bounds.len_lo);
          check_field("longest length",  out_max_length, due_now.bounds.len_hi);
          check_field("narrowest width", out_min_width,  due_now.bounds.wid_lo);
          check_field("widest width",    out_max_width,  due_now.bounds.wid_hi);
          check_field("row step",        out_row_step,   due_now.row_step);
          check_field("overflow", rdgs_pkg::coord_t'(out_overflow),
                      rdgs_pkg::coord_t'(due_now.bounds.overflow));
        end
        results_checked <= results_checked + 1;
      end
    end
    pending <= summaries_due.size();
  end

endmodule

>>> sim/rect_dimension_and_row_gap_stats_core_test.sv
// Top of the testbench for rect_dimension_and_row_gap_stats_core: drives sets of rectangles,
// idles the result side and gives the verdict. Depends on rdgs_pkg and the checker module.
module rect_dimension_and_row_gap_stats_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ITEMS       = 1024;
  // Stimulus stops once this many rectangle transfers have been made.
  localparam int RECT_TARGET     = 1300;
  // The oversized set is sent once this many sets have closed.
  localparam int OVERFLOW_AFTER  = 30;
  // The long receiver hold-off starts once this many summaries have been checked.
  localparam int HOLD_AFTER      = 12;
  localparam int HOLD_OFF_CYCLES = 400;
  // The drain leaves ample margin at the end of the run.
  localparam int DRAIN_CYCLES    = 200;
  // Cycles with no transfer on either channel before the run is abandoned. The worst
  // legitimate quiet stretch is the hold-off plus one division pass plus a long gap.
  localparam int WATCHDOG_LIMIT  = 4000;

  // How the scan row moves within one set.
  typedef enum int {
    ROWS_FIXED,
    ROWS_SCAN,
    ROWS_RANDOM
  } row_pattern_t;

  logic   clk   = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid;
  logic   in_ready;
  rdgs_pkg::coord_t in_rect_length;
  rdgs_pkg::coord_t in_rect_width;
  rdgs_pkg::coord_t in_scan_row;
  logic   in_last_item;
  logic   out_valid;
  logic   out_ready;
  rdgs_pkg::coord_t out_avg_length;
  rdgs_pkg::coord_t out_avg_width;
  rdgs_pkg::coord_t out_min_length;
  rdgs_pkg::coord_t out_max_length;
  rdgs_pkg::coord_t out_min_width;
  rdgs_pkg::coord_t out_max_width;
  rdgs_pkg::coord_t out_row_step;
  logic   out_overflow;

  int faults;
  int pending;
  int results_checked;

  int rects_sent     = 0;
  int sets_sent      = 0;
  int oversized_len  = 0;
  int quiet_cycles   = 0;
  bit sender_steady  = 1'b0;
  bit receiver_held  = 1'b0;
  bit hold_active    = 1'b0;

  always #10 clk = ~clk;

  rect_dimension_and_row_gap_stats_core #(
    .MAX_ITEMS(MAX_ITEMS)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_rect_length(in_rect_length),
    .in_rect_width (in_rect_width),
    .in_scan_row   (in_scan_row),
    .in_last_item  (in_last_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_avg_length(out_avg_length),
    .out_avg_width (out_avg_width),
    .out_min_length(out_min_length),
    .out_max_length(out_max_length),
    .out_min_width (out_min_width),
    .out_max_width (out_max_width),
    .out_row_step  (out_row_step),
    .out_overflow  (out_overflow)
  );

  // The checker sits beside the block and only observes; it owns all prediction.
  rect_dimension_and_row_gap_stats_checker #(
    .MAX_ITEMS(MAX_ITEMS)
  ) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rect_length (in_rect_length),
    .in_rect_width  (in_rect_width),
    .in_scan_row    (in_scan_row),
    .in_last_item   (in_last_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_avg_length (out_avg_length),
    .out_avg_width  (out_avg_width),
    .out_min_length (out_min_length),
    .out_max_length (out_max_length),
    .out_min_width  (out_min_width),
    .out_max_width  (out_max_width),
    .out_row_step   (out_row_step),
    .out_overflow   (out_overflow),
    .faults         (faults),
    .pending        (pending),
    .results_checked(results_checked)
  );

  // Coordinates lean towards the two ends of the range, so that the extremes and the
  // widest row gaps turn up often, but every bit still toggles through the random values.
  function automatic rdgs_pkg::coord_t pick_coord();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return rdgs_pkg::COORD_MAX;
    return rdgs_pkg::coord_t'($urandom_range(0, 4095));
  endfunction

  // Idle cycles before the next transfer: mostly none or a few, now and then a long
  // pause. While the sender is in a steady stretch it offers back to back.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (sender_steady || r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Most sets are short so that many summaries are checked; a few run to several dozen.
  function automatic int pick_set_size();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(1, 6);
    if (r < 9) return $urandom_range(7, 20);
    return $urandom_range(21, 60);
  endfunction

  // Offers one rectangle and returns at the edge where the transfer happens. Valid is
  // left high so that a following rectangle can go back to back without a bubble; the
  // only assignment to it in any one time step is made here or in hold_until_drained.
  task automatic send_rect(input rdgs_pkg::coord_t len, input rdgs_pkg::coord_t wid,
                           input rdgs_pkg::coord_t row, input logic last);
    int idle;
    idle = pick_gap();
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_rect_length <= len;
    in_rect_width  <= wid;
    in_scan_row    <= row;
    in_last_item   <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rects_sent++;
    if (last) sets_sent++;
  endtask

  // Withdraws the sender and waits until every closed set has produced its summary.
  // The checker updates its count at the clock edge, so the task waits for a clock edge
  // first, for a set closed at this very edge to show up in it.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_set(input int size, input row_pattern_t pattern);
    rdgs_pkg::coord_t row;
    rdgs_pkg::coord_t stride;
    row    = pick_coord();
    stride = rdgs_pkg::coord_t'($urandom_range(1, 64));
    sender_steady = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < size; k++) begin
      case (pattern)
        ROWS_FIXED: begin
          // The row never changes, so the block must fall back to its default step.
        end
        ROWS_SCAN: begin
          // A regular downward scan; wrapping past the bottom gives a large jump back.
          if (k != 0) row = row + stride;
        end
        default: begin
          // Repeats are kept likely so that gaps and non-gaps mix within a set.
          if ($urandom_range(0, 2) != 0) row = pick_coord();
        end
      endcase
      send_rect(pick_coord(), pick_coord(), row, k == size - 1);
    end
  endtask

  // Stimulus. Reset is held once at the start; everything after that is driven on the
  // rising edge.
  initial begin
    in_valid       <= 1'b0;
    in_rect_length <= '0;
    in_rect_width  <= '0;
    in_scan_row    <= '0;
    in_last_item   <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed sets. A lone rectangle at the bottom of every range, then one at the top;
    // neither has a row gap, so both report the default step.
    send_rect('0, '0, '0, 1'b1);
    send_rect(rdgs_pkg::COORD_MAX, rdgs_pkg::COORD_MAX, rdgs_pkg::COORD_MAX, 1'b1);
    // Two rectangles on the same row: still no gap, and the extremes cross over.
    send_rect(rdgs_pkg::COORD_MAX, '0, 12'd100, 1'b0);
    send_rect('0, rdgs_pkg::COORD_MAX, 12'd100, 1'b1);
    // The largest possible gap, taken upwards so that the absolute difference is needed.
    send_rect(12'd1, 12'd2, rdgs_pkg::COORD_MAX, 1'b0);
    send_rect(12'd3, 12'd4, '0, 1'b1);
    // A repeated first row followed by gaps in both directions.
    send_rect(12'd10, 12'd20, 12'd5, 1'b0);
    send_rect(12'd30, 12'd40, 12'd5, 1'b0);
    send_rect(12'd50, 12'd60, 12'd8, 1'b0);
    send_rect(12'd70, 12'd80, 12'd3, 1'b1);
    // Averages and the row step that only come out right if the division truncates.
    send_rect(12'd1, 12'd1, 12'd0, 1'b0);
    send_rect(12'd2, 12'd2, 12'd1, 1'b0);
    send_rect(12'd2, 12'd2, 12'd3, 1'b1);
    // Alternating bit patterns on every field.
    send_rect(12'hAAA, 12'h555, 12'hAAA, 1'b0);
    send_rect(12'h555, 12'hAAA, 12'h555, 1'b1);
    hold_until_drained();

    // Random sets. Once, part way through, a set runs past the item limit so that the
    // overflow flag and the frozen sums and counts are exercised; the sender then pauses
    // until the block has caught up. Elsewhere it pauses like that now and then at random,
    // but never during the receiver's long hold-off, so that the block really fills up.
    while (rects_sent < RECT_TARGET) begin
      if (oversized_len == 0 && sets_sent >= OVERFLOW_AFTER) begin
        oversized_len = MAX_ITEMS + $urandom_range(1, 4);
        send_set(oversized_len, row_pattern_t'($urandom_range(0, 2)));
        hold_until_drained();
      end else begin
        send_set(pick_set_size(), row_pattern_t'($urandom_range(0, 2)));
        if (!hold_active && $urandom_range(0, 7) == 0) hold_until_drained();
      end
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d summaries from %0d rectangle transfers in %0d sets, one set of %0d",
             results_checked, rects_sent, sets_sent, oversized_len);
    $display("rectangles past the item limit, and a %0d-cycle hold-off on the result side.",
             HOLD_OFF_CYCLES);
    if (faults == 0) begin
      $display("rect_dimension_and_row_gap_stats_core test passed");
    end else begin
      $display("rect_dimension_and_row_gap_stats_core test failed");
    end
    $finish;
  end

  // Result side. It alternates between ready stretches, some of them long with no idling
  // at all, and stalls. Once a dozen summaries have been checked it holds off for a long
  // stretch while the sender carries on: the output register fills, the next closed set
  // has nowhere to go, and the block must stall its input until the hold-off ends.
  initial begin
    int r;
    int span;
    out_ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!receiver_held && results_checked >= HOLD_AFTER) begin
        receiver_held = 1'b1;
        hold_active   = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_active   = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          out_ready <= 1'b1;
          span = $urandom_range(1, 8);
        end else if (r < 70) begin
          out_ready <= 1'b1;
          span = $urandom_range(20, 80);
        end else if (r < 94) begin
          out_ready <= 1'b0;
          span = $urandom_range(1, 3);
        end else begin
          out_ready <= 1'b0;
          span = $urandom_range(10, 50);
        end
        repeat (span) @(posedge clk);
      end
    end
  end

  // Watchdog: any transfer on either channel restarts the count of quiet cycles.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles, %0d summaries outstanding.",
               quiet_cycles, pending);
      $display("rect_dimension_and_row_gap_stats_core test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
